### sv/rdc_pkg.sv
`default_nettype none

package rdc_pkg;

    localparam int VALUE_W        = 31;
    localparam int BASE_W         = 6;
    localparam int CHAR_W         = 7;
    localparam int MAX_DIGITS_DEF = 32;

    localparam logic [BASE_W-1:0] MIN_BASE  = BASE_W'(2);
    localparam logic [BASE_W-1:0] MAX_BASE  = BASE_W'(36);
    localparam logic [BASE_W-1:0] DEC_LIMIT = BASE_W'(10);
    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(65);

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [BASE_W-1:0]  remainder;
    } t_div_res;

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_LIMIT) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/rdc_ram.sv
`default_nettype none

module rdc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  wire                       i_clk,
    input  wire                       i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0]  i_wr_addr,
    input  wire  [WIDTH-1:0]          i_wr_data,
    input  wire                       i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### sv/rdc_div.sv
`default_nettype none

module rdc_div
    import rdc_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire  [VALUE_W-1:0]  i_dividend,
    input  wire  [BASE_W-1:0]   i_divisor,
    output t_div_res            o_res
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [VALUE_W-1:0] r_quo, n_quo;
    logic [BASE_W-1:0]  r_rem, n_rem;
    logic [BASE_W-1:0]  r_div, n_div;

    logic [BASE_W:0]    rem_sh;
    logic [BASE_W:0]    diff;
    logic               ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh = {r_rem, r_quo[VALUE_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        ge     = (rem_sh >= {1'b0, r_div});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[VALUE_W-2:0], ge};
            n_rem = ge ? diff[BASE_W-1:0] : rem_sh[BASE_W-1:0];
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(VALUE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

`default_nettype wire

### sv/radix_digit_converter_top.sv
// channel | beat fields                               | handshake
// in      | i_value[30:0], i_base[5:0]                | i_in_valid / o_in_stall
// out     | o_digit_char[6:0], o_last_digit,          | o_out_valid / i_out_stall
//         | o_empty_number                            |
// one division by the base runs in the bit-serial divider, one division per digit
// each digit is then read from the stack ram and loaded into the output register, held by any output stall
// reset clears the control state only; the digit stack needs no clearing
// the input is stalled from acceptance until the last digit is in the output register
`default_nettype none

module radix_digit_converter_top
    import rdc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [VALUE_W-1:0]  i_value,
    input  wire  [BASE_W-1:0]   i_base,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [CHAR_W-1:0]   o_digit_char,
    output logic                o_last_digit,
    output logic                o_empty_number
);

    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_OUT  = 3'd3;
    localparam logic [2:0] ST_ZERO = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BASE_W-1:0]  r_base, n_base;
    logic               r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;
    logic               r_empty, n_empty;

    t_div_res           div_res;
    logic               div_start;
    logic [VALUE_W-1:0] div_dividend;
    logic [BASE_W-1:0]  div_divisor;

    logic               wr_en;
    logic               rd_en;
    logic [BASE_W-1:0]  rd_data;
    logic [CNT_W-1:0]   top_idx;

    logic               in_beat;
    logic               base_ok;
    logic               out_free;
    logic               quo_zero;

    assign in_beat  = i_in_valid && (r_state == ST_IDLE);
    assign base_ok  = (i_base >= MIN_BASE) && (i_base <= MAX_BASE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign quo_zero = (div_res.quotient == '0);
    assign top_idx  = r_cnt - CNT_W'(1);

    assign wr_en = (r_state == ST_DIV) && div_res.done && (r_cnt < CNT_W'(MAX_DIGITS));
    assign rd_en = (r_state == ST_RD);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = div_res.quotient;
        div_divisor  = r_base;
        if (r_state == ST_IDLE) begin
            div_dividend = i_value;
            div_divisor  = i_base;
            div_start    = in_beat && base_ok && (i_value != '0);
        end else if (r_state == ST_DIV) begin
            div_start = div_res.done && !quo_zero;
        end
    end

    rdc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_res      (div_res)
    );

    rdc_ram #(
        .WIDTH (BASE_W),
        .DEPTH (MAX_DIGITS)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_cnt[ADDR_W-1:0]),
        .i_wr_data (div_res.remainder),
        .i_rd_en   (rd_en),
        .i_rd_addr (top_idx[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_base      = r_base;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        n_empty     = r_empty;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_beat && base_ok) begin
                    n_base = i_base;
                    n_cnt  = '0;
                    if (i_value == '0) begin
                        n_state = ST_ZERO;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    if (wr_en) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    if (quo_zero) begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = digit_ascii(rd_data);
                    n_last      = (r_cnt == CNT_W'(1));
                    n_empty     = 1'b0;
                    n_cnt       = top_idx;
                    n_state     = (r_cnt == CNT_W'(1)) ? ST_IDLE : ST_RD;
                end
            end
            ST_ZERO: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CHAR_ZERO;
                    n_last      = 1'b1;
                    n_empty     = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_base  <= n_base;
        r_char  <= n_char;
        r_last  <= n_last;
        r_empty <= n_empty;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_digit_char   = r_char;
    assign o_last_digit   = r_last;
    assign o_empty_number = r_empty;

endmodule

`default_nettype wire
